// ===== sv/length_prefixed_record_fifo_assert.svh =====
// Assertion macros used by the checker file of the length-prefixed record fifo.
`ifndef LENGTH_PREFIXED_RECORD_FIFO_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_FIFO_ASSERT_SVH

// Clocked assertion, masked while reset is held.
`define LPRF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define LPRF_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lprf_pkg.sv =====
// Shared constants, types and helpers of the length-prefixed record fifo.
`timescale 1ns / 1ps

package lprf_pkg;

    // Store size and record limit
    localparam int DEPTH   = 256;
    localparam int MAX_LEN = 63;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int LEN_W  = 6;
    localparam int DATA_W = 8;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 9;

    // Derived widths: pointer, count (holds DEPTH itself), sum for space check
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    // Capacity after reset: 256 clamped to the store size
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'((DEPTH < 256) ? DEPTH : 256);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_HDR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DATA = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BUSY    = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_DATA
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              hdr_ok;      // reserve space, write length byte
        logic              data_wr;     // write one data byte
        logic              rd_issue;    // read store at read pointer, advance it
        logic              load_len;    // present length byte, release space
        logic              load_data;   // present one data byte
        logic              load_status; // present a status-only item
        logic [STAT_W-1:0] status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;     // output register can take an item this cycle
        logic pending_zero; // no put in progress
        logic count_zero;   // store holds no record
        logic no_space;     // header would not fit
        logic len_zero;     // length byte just read is zero
        logic rem_one;      // the data byte being presented is the final one
    } stat_t;

    // Pointer step with wrap at the capacity in use
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                              input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(p) + CNT_W'(1);
        return (nxt >= cap) ? '0 : AW'(nxt);
    endfunction

endpackage

// ===== sv/lprf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lprf_dp.sv =====
// Datapath: pointers, counters, capacity, ring store and output register.
`timescale 1ns / 1ps

module lprf_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lprf_pkg::cmd_t                   cmd,
    output lprf_pkg::stat_t                  st,
    input  logic [lprf_pkg::LEN_W-1:0]       s_rec_length,
    input  logic [lprf_pkg::DATA_W-1:0]      s_in_byte,
    input  logic                             cfg_wr_en,
    input  logic [lprf_pkg::CFG_W-1:0]       cfg_wr_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lprf_pkg::STAT_W-1:0]      m_status,
    output logic [lprf_pkg::DATA_W-1:0]      m_out_byte,
    output logic                             m_is_length,
    output logic                             m_last
);

    localparam int AW     = lprf_pkg::AW;
    localparam int CNT_W  = lprf_pkg::CNT_W;
    localparam int SUM_W  = lprf_pkg::SUM_W;
    localparam int LEN_W  = lprf_pkg::LEN_W;
    localparam int DATA_W = lprf_pkg::DATA_W;
    localparam int STAT_W = lprf_pkg::STAT_W;

    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  pending_reg, pending_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_out_byte_reg, m_out_byte_next;
    logic              m_is_length_reg, m_is_length_next;
    logic              m_last_reg, m_last_next;

    logic              ram_wr_en;
    logic [DATA_W-1:0] ram_wr_data;
    logic [DATA_W-1:0] ram_rd_data;
    logic [LEN_W-1:0]  rd_len;
    logic [SUM_W-1:0]  need_sum;
    logic [SUM_W-1:0]  release_amt;
    logic [CNT_W-1:0]  cap_clamped;

    // Ring store
    assign ram_wr_en   = cmd.hdr_ok | cmd.data_wr;
    assign ram_wr_data = cmd.hdr_ok ? DATA_W'(s_rec_length) : s_in_byte;

    lprf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (lprf_pkg::DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // Length field of a stored length byte
    assign rd_len      = ram_rd_data[LEN_W-1:0];
    assign need_sum    = SUM_W'(count_reg) + SUM_W'(s_rec_length) + SUM_W'(1);
    assign release_amt = SUM_W'(rd_len) + SUM_W'(1);

    // Capacity write value, clamped to 1..DEPTH
    always_comb begin
        if (cfg_wr_data == '0) begin
            cap_clamped = CNT_W'(1);
        end else if (int'(cfg_wr_data) > lprf_pkg::DEPTH) begin
            cap_clamped = CNT_W'(lprf_pkg::DEPTH);
        end else begin
            cap_clamped = CNT_W'(cfg_wr_data);
        end
    end

    // Status to controller
    always_comb begin
        st.out_free     = !m_valid_reg || m_ready;
        st.pending_zero = (pending_reg == '0);
        st.count_zero   = (count_reg == '0);
        st.no_space     = (int'(s_rec_length) > lprf_pkg::MAX_LEN) ||
                          (need_sum > SUM_W'(cap_reg));
        st.len_zero     = (rd_len == '0);
        st.rem_one      = (rem_reg == LEN_W'(1));
    end

    // Pointer and counter updates
    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        cap_next     = cap_reg;
        rem_next     = rem_reg;
        if (cfg_wr_en) begin
            wr_ptr_next  = '0;
            rd_ptr_next  = '0;
            count_next   = '0;
            pending_next = '0;
            cap_next     = cap_clamped;
        end else begin
            if (cmd.hdr_ok) begin
                count_next   = CNT_W'(need_sum);
                pending_next = s_rec_length;
                wr_ptr_next  = lprf_pkg::advance(wr_ptr_reg, cap_reg);
            end
            if (cmd.data_wr) begin
                pending_next = pending_reg - LEN_W'(1);
                wr_ptr_next  = lprf_pkg::advance(wr_ptr_reg, cap_reg);
            end
            if (cmd.rd_issue) begin
                rd_ptr_next = lprf_pkg::advance(rd_ptr_reg, cap_reg);
            end
            if (cmd.load_len) begin
                rem_next   = rd_len;
                count_next = (SUM_W'(count_reg) >= release_amt) ?
                             CNT_W'(SUM_W'(count_reg) - release_amt) : '0;
            end
            if (cmd.load_data) begin
                rem_next = rem_reg - LEN_W'(1);
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_out_byte_next  = m_out_byte_reg;
        m_is_length_next = m_is_length_reg;
        m_last_next      = m_last_reg;
        if (cmd.load_status) begin
            m_valid_next     = 1'b1;
            m_status_next    = cmd.status;
            m_out_byte_next  = '0;
            m_is_length_next = 1'b0;
            m_last_next      = 1'b1;
        end else if (cmd.load_len) begin
            m_valid_next     = 1'b1;
            m_status_next    = lprf_pkg::ST_OK;
            m_out_byte_next  = DATA_W'(rd_len);
            m_is_length_next = 1'b1;
            m_last_next      = st.len_zero;
        end else if (cmd.load_data) begin
            m_valid_next     = 1'b1;
            m_status_next    = lprf_pkg::ST_OK;
            m_out_byte_next  = ram_rd_data;
            m_is_length_next = 1'b0;
            m_last_next      = st.rem_one;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
            cap_reg     <= lprf_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rem_reg         <= rem_next;
        m_status_reg    <= m_status_next;
        m_out_byte_reg  <= m_out_byte_next;
        m_is_length_reg <= m_is_length_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_is_length = m_is_length_reg;
    assign m_last      = m_last_reg;

endmodule

// ===== sv/lprf_ctrl.sv =====
// Controller: request decode and the record read-out sequence.
`timescale 1ns / 1ps

module lprf_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lprf_pkg::REQ_W-1:0]  s_req_type,
    input  lprf_pkg::stat_t             st,
    output lprf_pkg::cmd_t              cmd
);

    lprf_pkg::state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lprf_pkg::S_IDLE: begin
                if (s_valid && st.out_free && (s_req_type == lprf_pkg::REQ_GET) &&
                    !st.count_zero && st.pending_zero) begin
                    state_next = lprf_pkg::S_LEN;
                end
            end
            lprf_pkg::S_LEN: begin
                if (st.out_free) begin
                    state_next = st.len_zero ? lprf_pkg::S_IDLE : lprf_pkg::S_DATA;
                end
            end
            lprf_pkg::S_DATA: begin
                if (st.out_free && st.rem_one) begin
                    state_next = lprf_pkg::S_IDLE;
                end
            end
            default: state_next = lprf_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            lprf_pkg::S_IDLE: begin
                s_ready = st.out_free;
                if (s_valid && st.out_free) begin
                    unique case (s_req_type)
                        lprf_pkg::REQ_HDR: begin
                            cmd.load_status = 1'b1;
                            if (!st.pending_zero) begin
                                cmd.status = lprf_pkg::ST_BUSY;
                            end else if (st.no_space) begin
                                cmd.status = lprf_pkg::ST_NOSPACE;
                            end else begin
                                cmd.status = lprf_pkg::ST_OK;
                                cmd.hdr_ok = 1'b1;
                            end
                        end
                        lprf_pkg::REQ_DATA: begin
                            // a stray data byte is dropped without a result
                            if (!st.pending_zero) begin
                                cmd.data_wr     = 1'b1;
                                cmd.load_status = 1'b1;
                                cmd.status      = lprf_pkg::ST_OK;
                            end
                        end
                        lprf_pkg::REQ_GET: begin
                            if (st.count_zero) begin
                                cmd.load_status = 1'b1;
                                cmd.status      = lprf_pkg::ST_EMPTY;
                            end else if (!st.pending_zero) begin
                                cmd.load_status = 1'b1;
                                cmd.status      = lprf_pkg::ST_BUSY;
                            end else begin
                                cmd.rd_issue = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lprf_pkg::S_LEN: begin
                if (st.out_free) begin
                    cmd.load_len = 1'b1;
                    cmd.rd_issue = !st.len_zero;
                end
            end
            lprf_pkg::S_DATA: begin
                if (st.out_free) begin
                    cmd.load_data = 1'b1;
                    cmd.rd_issue  = !st.rem_one;
                end
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lprf_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/length_prefixed_record_fifo.sv =====
// Put requests (header, data byte): one result item in the cycle after accept; one item per cycle
// while the output is not stalled. Get: the length byte comes through the registered store read
// and then the output register, then one data byte per cycle, paced by the single store port.
// No request is taken during the read-out; output stalls hold the current item and stop it.
// Reset (aresetn low, synchronous): pointers, count and pending length cleared, capacity
// 256 clamped to the store size; store contents are not cleared.
`timescale 1ns / 1ps

module length_prefixed_record_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lprf_pkg::REQ_W-1:0]  s_req_type,
    input  logic [lprf_pkg::LEN_W-1:0]  s_rec_length,
    input  logic [lprf_pkg::DATA_W-1:0] s_in_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lprf_pkg::STAT_W-1:0] m_status,
    output logic [lprf_pkg::DATA_W-1:0] m_out_byte,
    output logic                        m_is_length,
    output logic                        m_last,
    input  logic                        cfg_wr_en,
    input  logic [lprf_pkg::CFG_W-1:0]  cfg_wr_data
);

    lprf_pkg::cmd_t  cmd;
    lprf_pkg::stat_t st;

    // Sequencer
    lprf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .st         (st),
        .cmd        (cmd)
    );

    // Storage and output
    lprf_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .s_rec_length (s_rec_length),
        .s_in_byte    (s_in_byte),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_byte   (m_out_byte),
        .m_is_length  (m_is_length),
        .m_last       (m_last)
    );

endmodule

// ===== sv/lprf_checker.sv =====
// Port-level checker for the length-prefixed record fifo, bound to the top level.
`timescale 1ns / 1ps
`include "length_prefixed_record_fifo_assert.svh"

module lprf_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [lprf_pkg::REQ_W-1:0]  s_req_type,
    input logic [lprf_pkg::LEN_W-1:0]  s_rec_length,
    input logic [lprf_pkg::DATA_W-1:0] s_in_byte,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [lprf_pkg::STAT_W-1:0] m_status,
    input logic [lprf_pkg::DATA_W-1:0] m_out_byte,
    input logic                        m_is_length,
    input logic                        m_last,
    input logic                        cfg_wr_en,
    input logic [lprf_pkg::CFG_W-1:0]  cfg_wr_data
);

    // Stalled result item holds
    `LPRF_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_byte) && $stable(m_is_length) && $stable(m_last), "result item changed while stalled")

    // Error answers are single bare items
    `LPRF_ASSERT_RST(a_err_shape, aclk, aresetn, m_valid && (m_status != lprf_pkg::ST_OK) |-> m_last && !m_is_length && (m_out_byte == '0), "error item not a bare final item")

    // Length byte is in range and is final only for an empty record
    `LPRF_ASSERT_RST(a_len_shape, aclk, aresetn, m_valid && m_is_length |-> (m_out_byte[7:6] == 2'b00) && (m_last == (m_out_byte == '0)), "bad length byte item")

    // No new request taken in the middle of a record read-out
    `LPRF_ASSERT_RST(a_no_accept_mid, aclk, aresetn, m_valid && !m_last |-> !s_ready, "input ready during record read-out")

    // Reset leaves the output empty
    `LPRF_ASSERT_ANY(a_reset_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind length_prefixed_record_fifo lprf_checker u_lprf_checker (.*);
